// File: hw/rtl/sue_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sue_pkg
// Types and constants shared by the unit header encoder stages.
// ----------------------------------------------------------------------------
package sue_pkg;

    localparam int GROUP_BITS  = 7;
    localparam int MAX_VARINT  = 5;   // groups needed for a 32-bit value
    localparam int FIXED_MAX   = 8;   // widest fixed column field in bytes
    localparam int FIELD_W     = 32;  // width of the index fields

    // register indexes on the configuration port
    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_NEW_ROW_BIT  = 1'b0;
    localparam cfg_idx_t CFG_ROW_JUMP_BIT = 1'b1;

    localparam logic [2:0] NEW_ROW_BIT_RST  = 3'd7;
    localparam logic [2:0] ROW_JUMP_BIT_RST = 3'd6;

    // input item
    typedef struct packed {
        logic        new_row;
        logic [31:0] row_jump;
        logic [7:0]  pattern_id;
        logic [7:0]  unit_size;
        logic [31:0] column_index;
        logic [3:0]  column_bytes;
        logic        full_column;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_item_t;

    // header fields after the first stage
    typedef struct packed {
        logic [7:0] flag;
        logic [7:0] size;
        logic [3:0] nbytes;
        logic       full;
        logic [2:0] rj_len;
        logic [3:0] col_len;
    } prep_hdr_t;

    // fully encoded header, ready for the serializer
    typedef struct packed {
        logic [7:0]                  flag;
        logic [7:0]                  size;
        logic [MAX_VARINT-1:0][7:0]  rj_bytes;
        logic [FIXED_MAX-1:0][7:0]   col_bytes;
        logic [2:0]                  rj_len;
        logic [3:0]                  col_len;
    } enc_item_t;

    // number of 7-bit groups in the varint of v (a zero value takes one)
    function automatic logic [2:0] varint_len(input logic [FIELD_W-1:0] v);
        logic [2:0] len;
        if (|v[31:28])
            len = 3'd5;
        else if (|v[27:21])
            len = 3'd4;
        else if (|v[20:14])
            len = 3'd3;
        else if (|v[13:7])
            len = 3'd2;
        else
            len = 3'd1;
        return len;
    endfunction

endpackage

// File: hw/rtl/sparse_unit_header_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_unit_header_encoder_core
// Unit header encoder: flag byte, size byte, row jump varint, column field.
// ----------------------------------------------------------------------------
// Each accepted header comes out as a stream of 2 to 15 bytes, one per cycle
// unless the output is stalled: flag and size, then 0 to 5 row jump varint
// bytes, then the column field (0 to 8 fixed bytes or 1 to 5 varint bytes);
// the final byte has last_byte set. The single byte-wide output serializer
// sends all bytes of a header before it takes the next one.
// Headers pass through two pipeline stages ahead of the serializer, so up to
// three whole headers are held inside, plus the final byte of a fourth in the
// output register, while the output drains; a header passes the decode, byte
// build, serializer item and output registers. The user is to write the flag
// bit positions on the config port only while idle; this is not enforced.
module sparse_unit_header_encoder_core #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  sue_pkg::cfg_idx_t  cfg_index,
    input  logic [2:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  sue_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output sue_pkg::out_item_t out_item
);
    import sue_pkg::*;

    localparam int VAL_W = (INDEX_WIDTH < 32) ? INDEX_WIDTH : 32;

    logic             p_valid;
    logic             p_stall;
    prep_hdr_t        p_hdr;
    logic [VAL_W-1:0] p_rjmp;
    logic [VAL_W-1:0] p_col;
    logic             e_valid;
    logic             e_stall;
    enc_item_t        e_item;

    // header decode stage
    sue_prep #(.INDEX_WIDTH(INDEX_WIDTH)) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (p_valid),
        .out_stall (p_stall),
        .out_hdr   (p_hdr),
        .out_rjmp  (p_rjmp),
        .out_col   (p_col)
    );

    // byte build stage
    sue_enc #(.INDEX_WIDTH(INDEX_WIDTH)) u_enc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_stall  (p_stall),
        .in_hdr    (p_hdr),
        .in_rjmp   (p_rjmp),
        .in_col    (p_col),
        .out_valid (e_valid),
        .out_stall (e_stall),
        .out_item  (e_item)
    );

    // byte serializer
    sue_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e_valid),
        .in_stall  (e_stall),
        .in_item   (e_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// File: hw/rtl/sue_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sue_prep
// First stage: flag byte, index masking, varint lengths, flag bit registers.
// ----------------------------------------------------------------------------
module sue_prep #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  sue_pkg::cfg_idx_t                             cfg_index,
    input  logic [2:0]                                    cfg_data,
    input  logic                                          in_valid,
    output logic                                          in_stall,
    input  sue_pkg::in_item_t                             in_item,
    output logic                                          out_valid,
    input  logic                                          out_stall,
    output sue_pkg::prep_hdr_t                            out_hdr,
    output logic [(INDEX_WIDTH < 32 ? INDEX_WIDTH : 32)-1:0] out_rjmp,
    output logic [(INDEX_WIDTH < 32 ? INDEX_WIDTH : 32)-1:0] out_col
);
    import sue_pkg::*;

    localparam int VAL_W = (INDEX_WIDTH < 32) ? INDEX_WIDTH : 32;

    logic [2:0]       nr_bit_reg;
    logic [2:0]       rj_bit_reg;
    logic             valid_reg;
    prep_hdr_t        hdr_reg;
    prep_hdr_t        hdr_next;
    logic [VAL_W-1:0] rjmp_reg;
    logic [VAL_W-1:0] col_reg;
    logic [VAL_W-1:0] rjmp_m;
    logic [VAL_W-1:0] col_m;
    logic             rj_nz;
    logic             load;

    // flag bit position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nr_bit_reg <= NEW_ROW_BIT_RST;
            rj_bit_reg <= ROW_JUMP_BIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NEW_ROW_BIT:  nr_bit_reg <= cfg_data;
                CFG_ROW_JUMP_BIT: rj_bit_reg <= cfg_data;
                default:          nr_bit_reg <= nr_bit_reg;
            endcase
        end
    end

    // stage handshake
    assign in_stall = valid_reg && out_stall;
    assign load     = in_valid && !in_stall;

    // header decode
    always_comb
    begin
        rjmp_m = in_item.row_jump[VAL_W-1:0];
        col_m  = in_item.column_index[VAL_W-1:0];
        rj_nz  = (rjmp_m != '0);

        hdr_next.flag = in_item.pattern_id
                      | ({7'd0, in_item.new_row} << nr_bit_reg)
                      | ({7'd0, rj_nz} << rj_bit_reg);
        hdr_next.size = in_item.unit_size;
        // fixed field saturates at eight bytes
        hdr_next.nbytes = (in_item.column_bytes > 4'(FIXED_MAX)) ? 4'(FIXED_MAX)
                                                                : in_item.column_bytes;
        hdr_next.full   = in_item.full_column;
        hdr_next.rj_len = rj_nz ? varint_len(FIELD_W'(rjmp_m)) : 3'd0;
        hdr_next.col_len = in_item.full_column ? hdr_next.nbytes
                                               : {1'b0, varint_len(FIELD_W'(col_m))};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hdr_reg  <= hdr_next;
            rjmp_reg <= rjmp_m;
            col_reg  <= col_m;
        end
    end

    assign out_valid = valid_reg;
    assign out_hdr   = hdr_reg;
    assign out_rjmp  = rjmp_reg;
    assign out_col   = col_reg;

endmodule

// File: hw/rtl/sue_enc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sue_enc
// Second stage: builds the row jump varint and the column field bytes.
// ----------------------------------------------------------------------------
module sue_enc #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_stall,
    input  sue_pkg::prep_hdr_t                            in_hdr,
    input  logic [(INDEX_WIDTH < 32 ? INDEX_WIDTH : 32)-1:0] in_rjmp,
    input  logic [(INDEX_WIDTH < 32 ? INDEX_WIDTH : 32)-1:0] in_col,
    output logic                                          out_valid,
    input  logic                                          out_stall,
    output sue_pkg::enc_item_t                            out_item
);
    import sue_pkg::*;

    localparam int VARINT_W = MAX_VARINT * GROUP_BITS;
    localparam int FIXED_W  = FIXED_MAX * 8;

    logic [VARINT_W-1:0] rj_ext;
    logic [VARINT_W-1:0] cv_ext;
    logic [FIXED_W-1:0]  cf_ext;
    logic                valid_reg;
    enc_item_t           item_reg;
    enc_item_t           item_next;
    logic                load;

    assign in_stall = valid_reg && out_stall;
    assign load     = in_valid && !in_stall;

    // byte building
    always_comb
    begin
        rj_ext = VARINT_W'(in_rjmp);
        cv_ext = VARINT_W'(in_col);
        cf_ext = FIXED_W'(in_col);

        item_next.flag    = in_hdr.flag;
        item_next.size    = in_hdr.size;
        item_next.rj_len  = in_hdr.rj_len;
        item_next.col_len = in_hdr.col_len;

        // row jump groups, continuation bit on all but the last
        for (int g = 0; g < MAX_VARINT; g++)
        begin
            item_next.rj_bytes[g] = {(3'(g) + 3'd1 < in_hdr.rj_len),
                                     rj_ext[GROUP_BITS*g +: GROUP_BITS]};
        end

        // column field: little-endian fixed bytes
        for (int i = 0; i < FIXED_MAX; i++)
        begin
            item_next.col_bytes[i] = in_hdr.full ? cf_ext[8*i +: 8] : 8'd0;
        end

        // or varint groups in the low slots
        if (!in_hdr.full)
        begin
            for (int g = 0; g < MAX_VARINT; g++)
            begin
                item_next.col_bytes[g] = {(4'(g) + 4'd1 < in_hdr.col_len),
                                          cv_ext[GROUP_BITS*g +: GROUP_BITS]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: hw/rtl/sue_ser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sue_ser
// Third stage: sends the encoded header one byte per cycle, unless the
// output is stalled, through an output register.
// ----------------------------------------------------------------------------
module sue_ser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sue_pkg::enc_item_t in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output sue_pkg::out_item_t out_item
);
    import sue_pkg::*;

    logic       busy_reg;
    enc_item_t  item_reg;
    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic       oval_reg;
    out_item_t  oitem_reg;
    logic [3:0] total;
    logic [3:0] rel;
    logic [3:0] cidx;
    logic [7:0] cur_byte;
    logic       is_last;
    logic       adv;
    logic       load;

    // byte selection at the current position
    always_comb
    begin
        total   = 4'd2 + {1'b0, item_reg.rj_len} + item_reg.col_len;
        is_last = (pos_reg == total - 4'd1);
        rel     = pos_reg - 4'd2;
        cidx    = rel - {1'b0, item_reg.rj_len};
        if (pos_reg == 4'd0)
            cur_byte = item_reg.flag;
        else if (pos_reg == 4'd1)
            cur_byte = item_reg.size;
        else if (rel < {1'b0, item_reg.rj_len})
            cur_byte = item_reg.rj_bytes[rel[2:0]];
        else
            cur_byte = item_reg.col_bytes[cidx[2:0]];
        pos_next = is_last ? 4'd0 : pos_reg + 4'd1;
    end

    // handshake: item slot frees as its last byte moves out
    assign adv      = busy_reg && (!oval_reg || !out_stall);
    assign in_stall = busy_reg && !(adv && is_last);
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= 4'd0;
            oval_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= 4'd0;
            end
            else if (adv)
            begin
                busy_reg <= !is_last;
                pos_reg  <= pos_next;
            end

            if (adv)
                oval_reg <= 1'b1;
            else if (!out_stall)
                oval_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
        if (adv)
        begin
            oitem_reg.out_byte  <= cur_byte;
            oitem_reg.last_byte <= is_last;
        end
    end

    assign out_valid = oval_reg;
    assign out_item  = oitem_reg;

endmodule

// File: hw/rtl/sue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sue_checker
// Port-level checks on the unit header encoder, bound to the top level.
// ----------------------------------------------------------------------------
module sue_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input sue_pkg::out_item_t out_item
);
    import sue_pkg::*;

    logic [2:0] pend_reg;
    logic [3:0] bcnt_reg;
    logic       in_acc;
    logic       hdr_done;
    logic       out_acc;

    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;
    assign hdr_done = out_acc && out_item.last_byte;

    // headers accepted but not fully delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 3'd0;
        else if (in_acc && !hdr_done)
            pend_reg <= pend_reg + 3'd1;
        else if (!in_acc && hdr_done)
            pend_reg <= pend_reg - 3'd1;
    end

    // bytes delivered so far for the current header
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bcnt_reg <= 4'd0;
        else if (hdr_done)
            bcnt_reg <= 4'd0;
        else if (out_acc)
            bcnt_reg <= bcnt_reg + 4'd1;
    end

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    // no byte without a header in flight
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 3'd0)
        else $error("output byte with no pending header");

    // the pipeline holds at most four headers
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd4)
        else $error("more headers in flight than pipeline slots");

    // a header never runs past fifteen bytes
    a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bcnt_reg == 4'd14 |-> out_item.last_byte)
        else $error("header longer than fifteen bytes");

endmodule

bind sparse_unit_header_encoder_core sue_checker u_sue_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sparse unit header encoder core.
// ----------------------------------------------------------------------------
// A table of hand-picked headers runs first. Some rows carry their byte
// stream typed in, and the rest are checked against a local encoder. Random
// headers follow under several flag bit settings. Every output byte is
// compared in order against the queue of predicted bytes. Valid and stall
// are idled at random on both sides.
module testbench;
    import sue_pkg::*;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    cfg_idx_t  cfg_index = CFG_NEW_ROW_BIT;
    logic [2:0] cfg_data = 3'd0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    // flag bit positions as currently written into the block
    logic [2:0] nr_flag_bit = NEW_ROW_BIT_RST;
    logic [2:0] rj_flag_bit = ROW_JUMP_BIT_RST;

    out_item_t  expected_bytes[$];
    int         headers_sent  = 0;
    int         bytes_checked = 0;
    int         error_count   = 0;
    int         settings_used = 1;

    // idle rates in percent, changed per phase
    int unsigned out_stall_pct = 20;
    int unsigned in_gap_pct    = 20;
    int          stall_left    = 0;

    // directed table
    in_item_t    tbl_item[$];
    logic [2:0]  tbl_nr_bit[$];
    logic [2:0]  tbl_rj_bit[$];
    int          tbl_count[$];
    logic [119:0] tbl_golden[$];

    sparse_unit_header_encoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        if ($urandom_range(9, 0) == 0)
            return $urandom_range(40, 8);
        return $urandom_range(3, 1);
    endfunction

    // value with a random number of significant bits
    function automatic logic [31:0] rand_wide();
        return $urandom >> $urandom_range(31, 0);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        out_item_t r;
        r.out_byte  = b;
        r.last_byte = 1'b0;
        expected_bytes.push_back(r);
    endtask

    // 7-bit groups, low group first, continuation in bit 7
    task automatic push_varint(input logic [31:0] v);
        logic [31:0] rest;
        rest = v;
        while (rest > 32'h7F)
        begin
            push_byte({1'b1, rest[6:0]});
            rest = rest >> GROUP_BITS;
        end
        push_byte({1'b0, rest[6:0]});
    endtask

    // expected byte stream of one header under the current flag bits
    task automatic encode_header(input in_item_t h);
        logic [7:0]  flag;
        logic [63:0] col_wide;
        int          nb;
        int          k;
        flag = h.pattern_id;
        if (h.new_row)
            flag[nr_flag_bit] = 1'b1;
        if (h.row_jump != 32'd0)
            flag[rj_flag_bit] = 1'b1;
        push_byte(flag);
        push_byte(h.unit_size);
        if (h.row_jump != 32'd0)
            push_varint(h.row_jump);
        if (h.full_column)
        begin
            nb = (h.column_bytes > FIXED_MAX) ? FIXED_MAX : int'(h.column_bytes);
            col_wide = {32'd0, h.column_index};
            for (k = 0; k < nb; k++)
                push_byte(col_wide[8*k +: 8]);
        end
        else
        begin
            push_varint(h.column_index);
        end
        expected_bytes[expected_bytes.size()-1].last_byte = 1'b1;
    endtask

    // offer one header and wait until it is taken
    task automatic send_header(input in_item_t hdr, input int golden_n,
                               input logic [119:0] golden);
        int k;
        in_valid <= 1'b1;
        in_item  <= hdr;
        do
            @(posedge clk);
        while (in_stall);
        headers_sent++;
        if (golden_n == 0)
        begin
            encode_header(hdr);
        end
        else
        begin
            for (k = 0; k < golden_n; k++)
                push_byte(golden[8*(golden_n-1-k) +: 8]);
            expected_bytes[expected_bytes.size()-1].last_byte = 1'b1;
        end
    endtask

    task automatic idle_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // hold off until every predicted byte is out, plus pipeline settle
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_flag_bits(input logic [2:0] nr_bit, input logic [2:0] rj_bit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NEW_ROW_BIT;
        cfg_data  <= nr_bit;
        @(posedge clk);
        cfg_index <= CFG_ROW_JUMP_BIT;
        cfg_data  <= rj_bit;
        @(posedge clk);
        cfg_we <= 1'b0;
        nr_flag_bit = nr_bit;
        rj_flag_bit = rj_bit;
        settings_used++;
        @(posedge clk);
    endtask

    task automatic add_row(input logic [2:0] nr_bit, input logic [2:0] rj_bit,
                           input logic nr, input logic [31:0] rjmp,
                           input logic [7:0] pat, input logic [7:0] size,
                           input logic [31:0] col, input logic [3:0] nb,
                           input logic full, input int n, input logic [119:0] golden);
        in_item_t h;
        h.new_row      = nr;
        h.row_jump     = rjmp;
        h.pattern_id   = pat;
        h.unit_size    = size;
        h.column_index = col;
        h.column_bytes = nb;
        h.full_column  = full;
        tbl_item.push_back(h);
        tbl_nr_bit.push_back(nr_bit);
        tbl_rj_bit.push_back(rj_bit);
        tbl_count.push_back(n);
        tbl_golden.push_back(golden);
    endtask

    function automatic in_item_t random_header();
        in_item_t h;
        h.new_row    = 1'($urandom_range(1, 0));
        case ($urandom_range(3, 0))
            0: h.row_jump = 32'd0;
            1: h.row_jump = $urandom_range(255, 1);
            default: h.row_jump = rand_wide();
        endcase
        h.pattern_id   = 8'($urandom_range(255, 0));
        h.unit_size    = 8'($urandom_range(255, 0));
        h.column_index = rand_wide();
        if ($urandom_range(3, 0) == 0)
            h.column_bytes = 4'($urandom_range(15, 9));
        else
            h.column_bytes = 4'($urandom_range(8, 0));
        h.full_column = 1'($urandom_range(1, 0));
        return h;
    endfunction

    // receiver stall
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (out_stall_pct != 0 && $urandom_range(99, 0) < out_stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left <= pick_gap() - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // output checker
    always @(posedge clk)
    begin : check_out
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte %h last %b", $time,
                         out_item.out_byte, out_item.last_byte);
                error_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (out_item.out_byte !== want.out_byte)
                begin
                    $display("%0t: out_byte expected %h got %h", $time,
                             want.out_byte, out_item.out_byte);
                    error_count++;
                end
                if (out_item.last_byte !== want.last_byte)
                begin
                    $display("%0t: last_byte expected %b got %b", $time,
                             want.last_byte, out_item.last_byte);
                    error_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int row;
        int ph;
        int k;

        // reset flag bits: new row at 7, row jump at 6
        add_row(7, 6, 0, 32'h0,        8'h00, 8'h00, 32'h0,        0,  0, 3,
                {8'h00, 8'h00, 8'h00});
        add_row(7, 6, 1, 32'h0,        8'h01, 8'hFF, 32'h0,        0,  1, 2,
                {8'h81, 8'hFF});
        add_row(7, 6, 0, 32'h1,        8'h00, 8'h01, 32'hAB,       1,  1, 4,
                {8'h40, 8'h01, 8'h01, 8'hAB});
        add_row(7, 6, 1, 32'hFFFFFFFF, 8'hFF, 8'hFF, 32'hFFFFFFFF, 0,  0, 12,
                {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F});
        add_row(7, 6, 0, 32'h80,       8'h12, 8'h34, 32'h7F,       0,  0, 5,
                {8'h52, 8'h34, 8'h80, 8'h01, 8'h7F});
        // longest header: full jump varint and eight column bytes
        add_row(7, 6, 0, 32'hFFFFFFFF, 8'h00, 8'h0F, 32'h12345678, 8,  1, 15,
                {8'h40, 8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
                 8'h78, 8'h56, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00});
        // column byte count saturates at eight
        add_row(7, 6, 0, 32'h0,        8'h3C, 8'h80, 32'hFFFFFFFF, 15, 1, 10,
                {8'h3C, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'h00, 8'h00, 8'h00, 8'h00});
        // flags land on bits already set in the pattern id
        add_row(7, 6, 1, 32'h5,        8'hC0, 8'h00, 32'h3FFF,     0,  0, 5,
                {8'hC0, 8'h00, 8'h05, 8'hFF, 8'h7F});
        // no column bytes: last mark on the final jump byte
        add_row(7, 6, 0, 32'h100,      8'h00, 8'h00, 32'hDEAD,     0,  1, 4,
                {8'h40, 8'h00, 8'h80, 8'h02});
        add_row(7, 6, 0, 32'h0,        8'h00, 8'h00, 32'h1,        4,  1, 6,
                {8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00});
        // varint group boundaries
        add_row(7, 6, 0, 32'h3FFF,     8'h21, 8'h02, 32'h4000,     0,  0, 0, '0);
        add_row(7, 6, 1, 32'h200000,   8'h42, 8'h03, 32'h1FFFFF,   0,  0, 0, '0);
        add_row(7, 6, 0, 32'h10000000, 8'h84, 8'h04, 32'h0FFFFFFF, 0,  0, 0, '0);
        add_row(7, 6, 1, 32'h0,        8'h7E, 8'h05, 32'hA5A55A5A, 9,  1, 0, '0);
        add_row(7, 6, 0, 32'h0,        8'h55, 8'hAA, 32'h55555555, 12, 0, 0, '0);
        add_row(7, 6, 1, 32'h7F,       8'hAA, 8'h55, 32'hCAFE1234, 2,  1, 0, '0);
        // both flags on one bit
        add_row(3, 3, 1, 32'h2,        8'h00, 8'h01, 32'h5,        0,  0, 4,
                {8'h08, 8'h01, 8'h02, 8'h05});
        add_row(3, 3, 0, 32'h0,        8'h08, 8'h10, 32'h80,       0,  0, 0, '0);
        add_row(0, 0, 1, 32'h7F,       8'hFE, 8'hAA, 32'h00C0FFEE, 3,  1, 6,
                {8'hFF, 8'hAA, 8'h7F, 8'hEE, 8'hFF, 8'hC0});
        add_row(7, 7, 1, 32'h1,        8'h00, 8'h55, 32'h0,        0,  0, 4,
                {8'h80, 8'h55, 8'h01, 8'h00});
        add_row(7, 7, 0, 32'h0,        8'h7F, 8'h00, 32'hFFFF,     7,  1, 0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        for (row = 0; row < tbl_item.size(); row++)
        begin
            if (tbl_nr_bit[row] != nr_flag_bit || tbl_rj_bit[row] != rj_flag_bit)
            begin
                wait_for_idle();
                write_flag_bits(tbl_nr_bit[row], tbl_rj_bit[row]);
            end
            send_header(tbl_item[row], tbl_count[row], tbl_golden[row]);
            if ($urandom_range(99, 0) < in_gap_pct)
                idle_sender(pick_gap());
        end

        // random headers, one flag setting and idle mix per phase
        for (ph = 0; ph < 6; ph++)
        begin
            wait_for_idle();
            case (ph)
                0:
                begin
                    write_flag_bits(3'd0, 3'd0);
                    out_stall_pct = 30;
                    in_gap_pct    = 30;
                end
                1:
                begin
                    write_flag_bits(3'd7, 3'd7);
                    out_stall_pct = 0;
                    in_gap_pct    = 0;
                end
                2:
                begin
                    write_flag_bits(3'd0, 3'd7);
                    out_stall_pct = 60;
                    in_gap_pct    = 10;
                end
                3:
                begin
                    write_flag_bits(3'd7, 3'd0);
                    out_stall_pct = 10;
                    in_gap_pct    = 60;
                end
                default:
                begin
                    write_flag_bits(3'($urandom_range(7, 0)), 3'($urandom_range(7, 0)));
                    out_stall_pct = 35;
                    in_gap_pct    = 35;
                end
            endcase
            for (k = 0; k < 54; k++)
            begin
                send_header(random_header(), 0, '0);
                if ($urandom_range(39, 0) == 0)
                    wait_for_idle();
                else if ($urandom_range(99, 0) < in_gap_pct)
                    idle_sender(pick_gap());
            end
        end

        wait_for_idle();
        repeat (10) @(posedge clk);

        $display("covered %0d headers and %0d output bytes", headers_sent, bytes_checked);
        $display("under %0d flag bit settings, %0d errors", settings_used, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("timeout with %0d bytes outstanding", expected_bytes.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
